[src/ihe_pkg.sv]
// Shared request codes and constants for the intensity histogram engine.
`timescale 1ns / 1ps
`default_nettype none

package ihe_pkg;

   // Request action codes; the fourth code is ignored by the engine.
   localparam logic [1:0] ACT_CLEAR = 2'd0;
   localparam logic [1:0] ACT_COUNT = 2'd1;
   localparam logic [1:0] ACT_READ  = 2'd2;

   // Each bin also carries its count modulo the axis step, so rounding needs no divider.
   localparam int unsigned REM_WIDTH = 10;
   localparam logic [REM_WIDTH-1:0] AXIS_STEP = 10'd1000;
   localparam logic [REM_WIDTH-1:0] REM_LAST  = 10'd999;

   // Source of the bin word seen by the update stage.
   localparam logic [1:0] SEL_ZERO = 2'd0;
   localparam logic [1:0] SEL_MEM  = 2'd1;
   localparam logic [1:0] SEL_FWD  = 2'd2;

   typedef struct packed {
      logic rd_en;
      logic wr_en;
      logic clr;
   } mem_ctl_type;

endpackage

`default_nettype wire

[src/ihe_bin_mem.sv]
// Bin storage with per-entry valid bits, registered read and write-to-read bypass.
`timescale 1ns / 1ps
`default_nettype none

module ihe_bin_mem #(
   parameter int NUM_BINS = 256,
   parameter int AW       = 8,
   parameter int DW       = 42
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire ihe_pkg::mem_ctl_type ctl,
   input  wire logic [AW-1:0]       rd_addr,
   input  wire logic [AW-1:0]       wr_addr,
   input  wire logic [DW-1:0]       wr_data,
   output logic      [DW-1:0]       rd_data
);

   logic [DW-1:0]       mem [NUM_BINS];
   logic [NUM_BINS-1:0] valid_ff;
   logic [NUM_BINS-1:0] valid_in;
   logic [DW-1:0]       mem_rd_ff;
   logic [DW-1:0]       fwd_ff;
   logic [DW-1:0]       fwd_in;
   logic [1:0]          sel_ff;
   logic [1:0]          sel_in;

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (ctl.rd_en) begin
         mem_rd_ff <= mem[rd_addr];
      end
   end

   // A clear only drops the valid bits; an invalid entry reads as zero.
   always_comb begin
      valid_in = valid_ff;
      if (ctl.clr) begin
         valid_in = '0;
      end else if (ctl.wr_en) begin
         valid_in[wr_addr] = 1'b1;
      end
   end

   // The word written in this cycle is not yet in the array, so it is bypassed.
   always_comb begin
      sel_in = sel_ff;
      fwd_in = fwd_ff;
      if (ctl.rd_en) begin
         fwd_in = wr_data;
         if (ctl.clr) begin
            sel_in = ihe_pkg::SEL_ZERO;
         end else if (ctl.wr_en && (wr_addr == rd_addr)) begin
            sel_in = ihe_pkg::SEL_FWD;
         end else if (!valid_ff[rd_addr]) begin
            sel_in = ihe_pkg::SEL_ZERO;
         end else begin
            sel_in = ihe_pkg::SEL_MEM;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         sel_ff   <= ihe_pkg::SEL_ZERO;
      end else begin
         valid_ff <= valid_in;
         sel_ff   <= sel_in;
      end
      fwd_ff <= fwd_in;
   end

   always_comb begin
      case (sel_ff)
         ihe_pkg::SEL_MEM: rd_data = mem_rd_ff;
         ihe_pkg::SEL_FWD: rd_data = fwd_ff;
         default:          rd_data = '0;
      endcase
   end

endmodule

`default_nettype wire

[src/ihe_round_up.sv]
// Rounds the peak count up to the next multiple of the axis step.
`timescale 1ns / 1ps
`default_nettype none

module ihe_round_up #(
   parameter int CW = 32
) (
   input  wire logic [CW-1:0]                 peak,
   input  wire logic [ihe_pkg::REM_WIDTH-1:0] peak_rem,
   output logic      [32:0]                   axis_top
);

   localparam int SW = CW + ihe_pkg::REM_WIDTH + 1;

   logic [ihe_pkg::REM_WIDTH-1:0] gap;
   logic [SW-1:0]                 sum;
   logic [SW+32:0]                sum_ext;

   // An exact multiple, zero included, is returned unchanged.
   assign gap     = (peak_rem == '0) ? '0 : (ihe_pkg::AXIS_STEP - peak_rem);
   assign sum     = SW'(peak) + SW'(gap);
   assign sum_ext = {33'd0, sum};
   assign axis_top = sum_ext[32:0];

endmodule

`default_nettype wire

[src/intensity_histogram_engine.sv]
// Intensity histogram engine: one update stage between the bin memory and the result register.
// Throughput is one request per cycle while no read waits on a full result register;
// a count or clear is done in the cycle after acceptance. A read result passes the bin
// memory read register, loaded at acceptance, then the result register once the stage advances.
// Reset clears all bins and the peak at once through per-bin valid bits; no clearing pass.
// A clear request likewise drops all valid bits and the peak at once.
`timescale 1ns / 1ps
`default_nettype none

module intensity_histogram_engine #(
   parameter int NUM_BINS    = 256,
   parameter int COUNT_WIDTH = 32
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [1:0]  req_action,
   input  wire logic [7:0]  req_value,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic      [7:0]  rsp_bin_index,
   output logic      [31:0] rsp_bin_count,
   output logic      [31:0] rsp_peak_count,
   output logic      [32:0] rsp_axis_top,
   input  wire logic        csr_write_enable,
   input  wire logic        csr_write_data
);

   localparam int CW = COUNT_WIDTH;
   localparam int RW = ihe_pkg::REM_WIDTH;
   localparam int DW = CW + RW;
   localparam int AW = $clog2(NUM_BINS);
   localparam int IW = (AW > 8) ? AW : 8;

   logic req_accept;
   logic req_in_range;
   logic [IW-1:0] req_value_wide;
   logic [IW-1:0] s1_index_wide;

   logic       skip_ff;
   logic       s1_valid_ff, s1_valid_in;
   logic [1:0] s1_action_ff;
   logic [7:0] s1_index_ff;
   logic       s1_hit_ff;
   logic       s1_adv;
   logic       s1_count;

   ihe_pkg::mem_ctl_type mem_ctl;
   logic [DW-1:0] bin_word;
   logic [DW-1:0] bin_next;
   logic [CW-1:0] cnt;
   logic [RW-1:0] cnt_rem;
   logic [CW-1:0] cnt_new;
   logic [RW-1:0] rem_new;
   logic          cnt_sat;

   logic [CW-1:0] peak_ff, peak_in;
   logic [RW-1:0] peak_rem_ff, peak_rem_in;
   logic [32:0]   axis_top;

   logic [CW+31:0] bin_count_ext;
   logic [CW+31:0] peak_ext;
   logic           rsp_valid_ff, rsp_valid_in;
   logic [7:0]     rsp_bin_index_ff;
   logic [31:0]    rsp_bin_count_ff;
   logic [31:0]    rsp_peak_count_ff;
   logic [32:0]    rsp_axis_top_ff;

   // The update stage holds only when a read waits on a full result register.
   assign s1_adv    = s1_valid_ff && ((s1_action_ff != ihe_pkg::ACT_READ) ||
                                      !rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || s1_adv;
   assign req_accept = req_valid && req_ready;

   assign req_in_range   = {24'd0, req_value} < 32'(NUM_BINS);
   assign req_value_wide = IW'(req_value);
   assign s1_index_wide  = IW'(s1_index_ff);
   assign s1_count       = s1_valid_ff && (s1_action_ff == ihe_pkg::ACT_COUNT) && s1_hit_ff;

   assign mem_ctl.rd_en = req_accept && req_in_range &&
                          ((req_action == ihe_pkg::ACT_COUNT) ||
                           (req_action == ihe_pkg::ACT_READ));
   assign mem_ctl.wr_en = s1_count;
   assign mem_ctl.clr   = s1_valid_ff && (s1_action_ff == ihe_pkg::ACT_CLEAR);

   ihe_bin_mem #(
      .NUM_BINS (NUM_BINS),
      .AW       (AW),
      .DW       (DW)
   ) u_bin_mem (
      .clock   (clock),
      .reset   (reset),
      .ctl     (mem_ctl),
      .rd_addr (req_value_wide[AW-1:0]),
      .wr_addr (s1_index_wide[AW-1:0]),
      .wr_data (bin_next),
      .rd_data (bin_word)
   );

   // Saturated bins keep both their count and its remainder.
   assign cnt      = bin_word[CW-1:0];
   assign cnt_rem  = bin_word[DW-1:CW];
   assign cnt_sat  = (cnt == '1);
   assign cnt_new  = cnt_sat ? cnt : (cnt + 1'b1);
   assign rem_new  = cnt_sat ? cnt_rem :
                     ((cnt_rem == ihe_pkg::REM_LAST) ? '0 : (cnt_rem + 1'b1));
   assign bin_next = {rem_new, cnt_new};

   always_comb begin
      peak_in     = peak_ff;
      peak_rem_in = peak_rem_ff;
      if (mem_ctl.clr) begin
         peak_in     = '0;
         peak_rem_in = '0;
      end else if (s1_count && !(skip_ff && (s1_index_ff == 8'd0)) && (cnt_new > peak_ff)) begin
         peak_in     = cnt_new;
         peak_rem_in = rem_new;
      end
   end

   ihe_round_up #(
      .CW (CW)
   ) u_round_up (
      .peak     (peak_ff),
      .peak_rem (peak_rem_ff),
      .axis_top (axis_top)
   );

   assign bin_count_ext = {32'd0, (s1_hit_ff ? cnt : {CW{1'b0}})};
   assign peak_ext      = {32'd0, peak_ff};

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (s1_adv && (s1_action_ff == ihe_pkg::ACT_READ)) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         skip_ff      <= 1'b0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         peak_ff      <= '0;
         peak_rem_ff  <= '0;
      end else begin
         if (csr_write_enable) begin
            skip_ff <= csr_write_data;
         end
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         peak_ff      <= peak_in;
         peak_rem_ff  <= peak_rem_in;
      end
      if (req_accept) begin
         s1_action_ff <= req_action;
         s1_index_ff  <= req_value;
         s1_hit_ff    <= req_in_range;
      end
      if (s1_adv && (s1_action_ff == ihe_pkg::ACT_READ)) begin
         rsp_bin_index_ff  <= s1_index_ff;
         rsp_bin_count_ff  <= bin_count_ext[31:0];
         rsp_peak_count_ff <= peak_ext[31:0];
         rsp_axis_top_ff   <= axis_top;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_bin_index  = rsp_bin_index_ff;
   assign rsp_bin_count  = rsp_bin_count_ff;
   assign rsp_peak_count = rsp_peak_count_ff;
   assign rsp_axis_top   = rsp_axis_top_ff;

endmodule

`default_nettype wire

[src/ihe_checker.sv]
// Port-level checks for the intensity histogram engine, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module ihe_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_ready,
   input wire logic [1:0]  req_action,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [7:0]  rsp_bin_index,
   input wire logic [31:0] rsp_bin_count,
   input wire logic [31:0] rsp_peak_count,
   input wire logic [32:0] rsp_axis_top
);

   // A stalled result keeps its contents.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_bin_index) &&
         $stable(rsp_bin_count) && $stable(rsp_peak_count) && $stable(rsp_axis_top))
      else $error("result changed while stalled");

   // No result is pending right after reset.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // With the result register empty nothing can hold the update stage.
   assert property (@(posedge clock) disable iff (reset) !rsp_valid |-> req_ready)
      else $error("request refused with empty result register");

   // A newly valid result comes from an accepted read request.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready &&
                                 (req_action == ihe_pkg::ACT_READ), 2))
      else $error("result without a matching read request");

endmodule

bind intensity_histogram_engine ihe_checker u_ihe_checker (.*);

`default_nettype wire

[bench/tb.sv]
// Self-checking testbench for the histogram engine: directed table, random traffic, a bin flood.
`timescale 1ns / 1ps

module tb;

   localparam int unsigned BIN_TOTAL      = 256;
   localparam int unsigned COUNT_BITS     = 32;
   localparam longint unsigned AXIS_GRID  = 1000;
   localparam logic [1:0]  ACT_UNUSED     = 2'd3;
   localparam int unsigned SETTLE_CYCLES  = 4;
   localparam int unsigned TAIL_CYCLES    = 8;
   localparam int unsigned WATCHDOG_LIMIT = 2000;
   localparam int unsigned FLOOD_COUNTS   = 270;
   localparam int unsigned PHASE_ITEMS    = 75;

   typedef struct packed {
      logic [7:0]  bin_index;
      logic [31:0] bin_count;
      logic [31:0] peak_count;
      logic [32:0] axis_top;
   } read_result_type;

   typedef enum logic {ROW_REQUEST, ROW_CSR} row_kind_type;

   typedef struct {
      row_kind_type    kind;
      logic [1:0]      action;
      logic [7:0]      value;
      bit              typed;
      read_result_type want;
   } stim_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_action = ihe_pkg::ACT_CLEAR;
   logic [7:0]  req_value = 8'd0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [7:0]  rsp_bin_index;
   logic [31:0] rsp_bin_count;
   logic [31:0] rsp_peak_count;
   logic [32:0] rsp_axis_top;
   logic        csr_write_enable = 1'b0;
   logic        csr_write_data = 1'b0;

   // Predictor state.
   logic [COUNT_BITS-1:0] hist_bins [0:BIN_TOTAL-1];
   logic [COUNT_BITS-1:0] hist_peak;
   logic                  skip_bin0;

   read_result_type pending_reads [$];
   int unsigned  mismatch_count = 0;
   int unsigned  idle_cycles = 0;
   int unsigned  stall_left = 0;
   bit           stalls_on = 1'b0;
   bit           sender_gaps_on = 1'b0;

   intensity_histogram_engine #(
      .NUM_BINS    (BIN_TOTAL),
      .COUNT_WIDTH (COUNT_BITS)
   ) u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_action       (req_action),
      .req_value        (req_value),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_bin_index    (rsp_bin_index),
      .rsp_bin_count    (rsp_bin_count),
      .rsp_peak_count   (rsp_peak_count),
      .rsp_axis_top     (rsp_axis_top),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // Directed rows; a zero want with typed clear means the predictor supplies the expectation.
   stim_row_type directed_rows [0:24] = '{
      '{ROW_REQUEST, ihe_pkg::ACT_READ,  8'h00, 1'b1, {8'h00, 32'd0, 32'd0, 33'd0}},
      '{ROW_REQUEST, ihe_pkg::ACT_READ,  8'hFF, 1'b1, {8'hFF, 32'd0, 32'd0, 33'd0}},
      '{ROW_REQUEST, ACT_UNUSED,         8'hFF, 1'b0, '0},
      '{ROW_REQUEST, ihe_pkg::ACT_COUNT, 8'h00, 1'b0, '0},
      '{ROW_REQUEST, ihe_pkg::ACT_COUNT, 8'hFF, 1'b0, '0},
      '{ROW_REQUEST, ihe_pkg::ACT_COUNT, 8'hFF, 1'b0, '0},
      '{ROW_REQUEST, ihe_pkg::ACT_READ,  8'hFF, 1'b1, {8'hFF, 32'd2, 32'd2, 33'd1000}},
      '{ROW_REQUEST, ihe_pkg::ACT_READ,  8'h00, 1'b1, {8'h00, 32'd1, 32'd2, 33'd1000}},
      '{ROW_REQUEST, ihe_pkg::ACT_COUNT, 8'h55, 1'b0, '0},
      '{ROW_REQUEST, ACT_UNUSED,         8'hAA, 1'b0, '0},
      '{ROW_REQUEST, ihe_pkg::ACT_READ,  8'h55, 1'b0, '0},
      '{ROW_REQUEST, ihe_pkg::ACT_CLEAR, 8'hFF, 1'b0, '0},
      '{ROW_REQUEST, ihe_pkg::ACT_READ,  8'hFF, 1'b1, {8'hFF, 32'd0, 32'd0, 33'd0}},
      '{ROW_CSR,     ihe_pkg::ACT_CLEAR, 8'h01, 1'b0, '0},
      '{ROW_REQUEST, ihe_pkg::ACT_COUNT, 8'h00, 1'b0, '0},
      '{ROW_REQUEST, ihe_pkg::ACT_COUNT, 8'h00, 1'b0, '0},
      '{ROW_REQUEST, ihe_pkg::ACT_READ,  8'h00, 1'b1, {8'h00, 32'd2, 32'd0, 33'd0}},
      '{ROW_REQUEST, ihe_pkg::ACT_COUNT, 8'hAA, 1'b0, '0},
      '{ROW_REQUEST, ihe_pkg::ACT_READ,  8'hAA, 1'b1, {8'hAA, 32'd1, 32'd1, 33'd1000}},
      '{ROW_CSR,     ihe_pkg::ACT_CLEAR, 8'h00, 1'b0, '0},
      '{ROW_REQUEST, ihe_pkg::ACT_READ,  8'h00, 1'b1, {8'h00, 32'd2, 32'd1, 33'd1000}},
      '{ROW_REQUEST, ihe_pkg::ACT_COUNT, 8'h00, 1'b0, '0},
      '{ROW_REQUEST, ihe_pkg::ACT_READ,  8'h00, 1'b1, {8'h00, 32'd3, 32'd3, 33'd1000}},
      '{ROW_REQUEST, ihe_pkg::ACT_CLEAR, 8'h00, 1'b0, '0},
      '{ROW_REQUEST, ihe_pkg::ACT_READ,  8'h55, 1'b1, {8'h55, 32'd0, 32'd0, 33'd0}}
   };

   function automatic logic [32:0] round_to_axis(input logic [31:0] peak_val);
      longint unsigned p;
      longint unsigned rem;
      p = {32'd0, peak_val};
      rem = p % AXIS_GRID;
      if (rem == 0) begin
         return p[32:0];
      end
      return 33'(p + (AXIS_GRID - rem));
   endfunction

   function automatic void clear_histogram();
      foreach (hist_bins[i]) begin
         hist_bins[i] = '0;
      end
      hist_peak = '0;
   endfunction

   // Queues one expected read result behind those already outstanding.
   function automatic void expect_read(input read_result_type res);
      pending_reads = {pending_reads, res};
   endfunction

   // Applies one accepted request to the predictor; returns 1 when a read result is due.
   function automatic bit histogram_step(input logic [1:0] act, input logic [7:0] val,
                                         output read_result_type res);
      logic [COUNT_BITS-1:0] c;
      res = '0;
      case (act)
         ihe_pkg::ACT_CLEAR: begin
            clear_histogram();
         end
         ihe_pkg::ACT_COUNT: begin
            if (val < BIN_TOTAL) begin
               c = hist_bins[val];
               if (c != '1) begin
                  c = c + 1'b1;
               end
               hist_bins[val] = c;
               if (!(skip_bin0 && val == 8'd0) && c > hist_peak) begin
                  hist_peak = c;
               end
            end
         end
         ihe_pkg::ACT_READ: begin
            res.bin_index  = val;
            res.bin_count  = (val < BIN_TOTAL) ? hist_bins[val][31:0] : 32'd0;
            res.peak_count = hist_peak[31:0];
            res.axis_top   = round_to_axis(hist_peak[31:0]);
            return 1'b1;
         end
         default: begin
         end
      endcase
      return 1'b0;
   endfunction

   // Mostly short pauses, now and then a long one.
   function automatic int unsigned idle_length();
      if ($urandom_range(0, 9) == 0) begin
         return $urandom_range(8, 40);
      end
      return $urandom_range(1, 3);
   endfunction

   task automatic send_request(input logic [1:0] act, input logic [7:0] val, input bit typed,
                               input read_result_type want);
      read_result_type predicted;
      int unsigned  gap;
      req_action <= act;
      req_value  <= val;
      req_valid  <= 1'b1;
      do begin
         @(posedge clock);
      end while (!req_ready);
      if (histogram_step(act, val, predicted)) begin
         expect_read(typed ? want : predicted);
      end
      gap = 0;
      if (sender_gaps_on && $urandom_range(0, 1) == 1) begin
         gap = idle_length();
      end
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Counts may still be in flight after the last read result, so settle before a register write.
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pending_reads.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_skip(input logic bit_val);
      wait_idle();
      csr_write_enable <= 1'b1;
      csr_write_data   <= bit_val;
      @(posedge clock);
      skip_bin0 = bit_val;
      csr_write_enable <= 1'b0;
   endtask

   task automatic random_phase(input int unsigned n_items);
      int unsigned done_items;
      int unsigned r;
      logic [1:0]  act;
      logic [7:0]  val;
      logic [7:0]  hot_a;
      logic [7:0]  hot_b;
      done_items = 0;
      hot_a = 8'($urandom_range(0, 255));
      hot_b = 8'($urandom_range(0, 255));
      while (done_items < n_items) begin
         r = $urandom_range(0, 99);
         if (r < 2) begin
            act = ihe_pkg::ACT_CLEAR;
         end else if (r < 5) begin
            act = ACT_UNUSED;
         end else if (r < 35) begin
            act = ihe_pkg::ACT_READ;
         end else begin
            act = ihe_pkg::ACT_COUNT;
         end
         // Concentrate on a few bins so that peaks grow and bin 0 is exercised often.
         r = $urandom_range(0, 9);
         if (r < 2) begin
            val = 8'd0;
         end else if (r < 4) begin
            val = hot_a;
         end else if (r < 6) begin
            val = hot_b;
         end else begin
            val = 8'($urandom_range(0, 255));
         end
         send_request(act, val, 1'b0, '0);
         if (act != ACT_UNUSED) begin
            done_items++;
         end
      end
   endtask

   // Drives one bin to a high count with a long run of back-to-back counts.
   task automatic flood_phase();
      send_request(ihe_pkg::ACT_CLEAR, 8'd0, 1'b0, '0);
      repeat (FLOOD_COUNTS) send_request(ihe_pkg::ACT_COUNT, 8'd0, 1'b0, '0);
      send_request(ihe_pkg::ACT_READ, 8'd0, 1'b0, '0);
      send_request(ihe_pkg::ACT_COUNT, 8'd0, 1'b0, '0);
      send_request(ihe_pkg::ACT_READ, 8'd0, 1'b0, '0);
   endtask

   always @(posedge clock) begin
      if (stall_left != 0) begin
         rsp_ready  <= 1'b0;
         stall_left <= stall_left - 1;
      end else if (stalls_on && $urandom_range(0, 99) < 20) begin
         rsp_ready  <= 1'b0;
         stall_left <= idle_length() - 1;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      read_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_reads.size() == 0) begin
            $error("read result with no request outstanding: bin_index %0d", rsp_bin_index);
            mismatch_count++;
         end else begin
            want = pending_reads.pop_front();
            if (rsp_bin_index !== want.bin_index) begin
               $error("bin_index: expected %0d, got %0d", want.bin_index, rsp_bin_index);
               mismatch_count++;
            end
            if (rsp_bin_count !== want.bin_count) begin
               $error("bin_count: expected %0d, got %0d", want.bin_count, rsp_bin_count);
               mismatch_count++;
            end
            if (rsp_peak_count !== want.peak_count) begin
               $error("peak_count: expected %0d, got %0d", want.peak_count, rsp_peak_count);
               mismatch_count++;
            end
            if (rsp_axis_top !== want.axis_top) begin
               $error("axis_top: expected %0d, got %0d", want.axis_top, rsp_axis_top);
               mismatch_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      clear_histogram();
      skip_bin0 = 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed table, no idling on either side.
      foreach (directed_rows[i]) begin
         if (directed_rows[i].kind == ROW_CSR) begin
            write_skip(directed_rows[i].value[0]);
         end else begin
            send_request(directed_rows[i].action, directed_rows[i].value,
                         directed_rows[i].typed, directed_rows[i].want);
         end
      end

      write_skip(1'b0);
      sender_gaps_on <= 1'b1;
      stalls_on      <= 1'b1;
      random_phase(PHASE_ITEMS);

      write_skip(1'b1);
      sender_gaps_on <= 1'b0;
      stalls_on      <= 1'b0;
      random_phase(PHASE_ITEMS);

      write_skip(1'($urandom_range(0, 1)));
      sender_gaps_on <= 1'b1;
      stalls_on      <= 1'b1;
      random_phase(PHASE_ITEMS);

      write_skip(1'b0);
      sender_gaps_on <= 1'b0;
      stalls_on      <= 1'b1;
      flood_phase();

      write_skip(1'b1);
      sender_gaps_on <= 1'b1;
      random_phase(PHASE_ITEMS);

      req_valid <= 1'b0;
      while (pending_reads.size() != 0) begin
         @(posedge clock);
      end
      repeat (TAIL_CYCLES) @(posedge clock);

      if (mismatch_count == 0 && pending_reads.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
